/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the permutation and binomial counter
// Holds the field widths, the argument bound and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    // field widths
    localparam int ARG_W   = 5;
    localparam int ORD_W   = 62;
    localparam int CHS_W   = 18;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 80;
    localparam int CNT_W   = 6;

    // largest n or k accepted
    localparam logic [ARG_W-1:0] MAX_N = 5'd20;

    // one quotient bit per division step
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd62;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } bpc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic skip;
        logic mul_done;
        logic div_done;
        logic out_free;
    } bpc_sts_t;

endpackage

`default_nettype wire

/* rtl/bpc_ctrl.sv */
// ----------------------------------------------------------------------------
// bpc_ctrl: sequencing controller
// Steps one item through operand load, the product loop, the division and
// the hand-over to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bpc_pkg::bpc_sts_t sts,
    output bpc_pkg::bpc_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (sts.skip) begin
                    state_next = ST_FIN;
                end else if (sts.mul_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bpc_dp.sv */
// ----------------------------------------------------------------------------
// bpc_dp: arithmetic datapath
// Accumulates the falling factorial and k!, divides one bit per cycle and
// holds the finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [bpc_pkg::IN_W-1:0]      s_tdata,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [bpc_pkg::OUT_W-1:0]          m_tdata,
    output logic [0:0]                         m_tuser,
    input  wire bpc_pkg::bpc_cmd_t             cmd,
    output bpc_pkg::bpc_sts_t                  sts
);

    localparam int AW = bpc_pkg::ARG_W;
    localparam int OW = bpc_pkg::ORD_W;

    logic [AW-1:0]                n_reg;
    logic [AW-1:0]                k_reg;
    logic [AW-1:0]                i_reg;
    logic [OW-1:0]                prod_reg;
    logic [OW-1:0]                fact_reg;
    logic [OW-1:0]                rem_reg;
    logic [OW-1:0]                quo_reg;
    logic [bpc_pkg::CNT_W-1:0]    div_cnt_reg;
    logic                         m_tvalid_reg;
    logic [bpc_pkg::OUT_W-1:0]    m_tdata_reg;
    logic                         ovf_out_reg;

    logic                         ovf;
    logic [AW-1:0]                mul_factor;
    logic [OW-1:0]                prod_mul;
    logic [OW-1:0]                fact_mul;
    logic [AW-1:0]                i_inc;
    logic [OW:0]                  rem_shift;
    logic [OW:0]                  div_ext;
    logic                         div_ge;
    logic [OW:0]                  rem_sub;

    // argument checks
    assign ovf = (n_reg > bpc_pkg::MAX_N) || (k_reg > bpc_pkg::MAX_N);

    // one factor of each product per step
    assign i_inc      = i_reg + 1'b1;
    assign mul_factor = n_reg - i_reg;
    assign prod_mul   = prod_reg * {{(OW-AW){1'b0}}, mul_factor};
    assign fact_mul   = fact_reg * {{(OW-AW){1'b0}}, i_inc};

    // restoring division step: shift in the next dividend bit, try subtract
    assign rem_shift = {rem_reg, quo_reg[OW-1]};
    assign div_ext   = {1'b0, fact_reg};
    assign div_ge    = (rem_shift >= div_ext);
    assign rem_sub   = rem_shift - div_ext;

    // status towards the controller
    assign sts.skip     = ovf || (k_reg > n_reg);
    assign sts.mul_done = (i_reg == k_reg);
    assign sts.div_done = (div_cnt_reg == bpc_pkg::DIV_STEPS);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= s_tdata[AW-1:0];
            k_reg    <= s_tdata[2*AW-1:AW];
            i_reg    <= '0;
            prod_reg <= {{(OW-1){1'b0}}, 1'b1};
            fact_reg <= {{(OW-1){1'b0}}, 1'b1};
        end else if (cmd.mul_step) begin
            i_reg    <= i_inc;
            prod_reg <= prod_mul;
            fact_reg <= fact_mul;
        end
        if (cmd.div_init) begin
            rem_reg     <= '0;
            quo_reg     <= prod_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= div_ge ? rem_sub[OW-1:0] : rem_shift[OW-1:0];
            quo_reg     <= {quo_reg[OW-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (sts.skip) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {quo_reg[bpc_pkg::CHS_W-1:0], prod_reg};
            end
            ovf_out_reg <= ovf;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = ovf_out_reg;

endmodule

`default_nettype wire

/* rtl/binomial_and_permutation_count.sv */
// ----------------------------------------------------------------------------
// binomial_and_permutation_count: falling factorial and binomial coefficient
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// For each (n, k) transfer the block returns n*(n-1)*...*(n-k+1) and that
// product divided by k!. k = 0 gives 1 for both; k > n gives 0 for both; n or
// k above 20 raises the overflow flag with both counts zero. One item is in
// work at a time: an item passes from the input transfer through the multiply
// loop and the bit-serial restoring divider to the result register;
// out-of-range items and k > n skip the loop and the divider.
// The result sits in an output register, so a new item is taken while the
// previous result waits for the downstream side.
`default_nettype none

module binomial_and_permutation_count (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [4:0] n_total, [9:5] k_chosen, [15:10] zero
    input  wire logic [15:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [61:0] ordered_count, [79:62] choose_count
    output logic [79:0]       m_tdata,
    // [0] overflow
    output logic [0:0]        m_tuser
);

    bpc_pkg::bpc_cmd_t cmd;
    bpc_pkg::bpc_sts_t sts;

    // sequencing
    bpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and result register
    bpc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef SYNTHESIS
    // overflow results carry zero counts
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 80'd0)
        else $error("overflow result with non-zero counts");

    // a binomial count is never present without its ordered count
    a_choose_ord: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[79:62] != 18'd0) |-> m_tdata[61:0] != 62'd0)
        else $error("choose count set while ordered count is zero");

    // the block is busy in the cycle after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transfer");
`endif

endmodule

`default_nettype wire

/* sim/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker: result checker for the permutation and binomial counter
// Watches both streams, works out the falling factorial, the binomial
// coefficient and the overflow flag for every accepted (n, k) pair, and
// compares each output transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bpc_checker
    import bpc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [15:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [79:0]  m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                fail_count,
    output int                counts_pending
);

    typedef struct {
        logic [ARG_W-1:0] n_total;
        logic [ARG_W-1:0] k_chosen;
        logic [ORD_W-1:0] ordered_count;
        logic [CHS_W-1:0] choose_count;
        logic             overflow;
    } count_result_t;

    count_result_t expected_counts[$];
    int            report_count = 0;

    // n!/(n-k)! and n choose k, both zero past the bound or for k > n
    function automatic count_result_t predict_counts(logic [ARG_W-1:0] n,
                                                     logic [ARG_W-1:0] k);
        count_result_t r;
        logic [63:0]   falling;
        logic [63:0]   k_fact;
        logic [63:0]   quotient;
        int            i;
        r.n_total       = n;
        r.k_chosen      = k;
        r.ordered_count = '0;
        r.choose_count  = '0;
        r.overflow      = (n > MAX_N) || (k > MAX_N);
        if (!r.overflow && k <= n) begin
            falling = 64'd1;
            k_fact  = 64'd1;
            for (i = 0; i < int'(k); i++) begin
                falling = falling * (64'(n) - 64'(i));
                k_fact  = k_fact * 64'(i + 1);
            end
            quotient        = falling / k_fact;
            r.ordered_count = falling[ORD_W-1:0];
            r.choose_count  = quotient[CHS_W-1:0];
        end
        return r;
    endfunction

    function automatic void note_failure(string what);
        fail_count++;
        if (report_count < 10) begin
            report_count++;
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    initial begin
        fail_count     = 0;
        counts_pending = 0;
    end

    // compare output transfers first, then record the new input transfer
    always @(posedge aclk) begin
        count_result_t    want;
        logic [ORD_W-1:0] got_ordered;
        logic [CHS_W-1:0] got_choose;
        logic             got_overflow;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_ordered  = m_tdata[ORD_W-1:0];
                got_choose   = m_tdata[ORD_W+CHS_W-1:ORD_W];
                got_overflow = m_tuser[0];
                if (expected_counts.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result ordered=%0d choose=%0d overflow=%0d",
                        got_ordered, got_choose, got_overflow));
                end else begin
                    want = expected_counts.pop_front();
                    if (got_ordered !== want.ordered_count
                            || got_choose !== want.choose_count
                            || got_overflow !== want.overflow) begin
                        note_failure($sformatf(
                            {"n=%0d k=%0d: expected ordered=%0d choose=%0d ",
                             "overflow=%0d, got ordered=%0d choose=%0d overflow=%0d"},
                            want.n_total, want.k_chosen, want.ordered_count,
                            want.choose_count, want.overflow,
                            got_ordered, got_choose, got_overflow));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_counts.push_back(predict_counts(s_tdata[ARG_W-1:0],
                                                         s_tdata[2*ARG_W-1:ARG_W]));
            end
            counts_pending = expected_counts.size();
        end
    end

endmodule

/* sim/tb_binomial_and_permutation_count.sv */
// ----------------------------------------------------------------------------
// tb_binomial_and_permutation_count: testbench for the permutation counter
// Drives directed corner pairs and then random (n, k) pairs with random gaps
// on the input side and random stalls on the output side; the checker beside
// the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_binomial_and_permutation_count;
    import bpc_pkg::*;

    localparam int RANDOM_PAIRS = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [4:0] n_total, [9:5] k_chosen, [15:10] zero
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [61:0] ordered_count, [79:62] choose_count
    logic [79:0] m_tdata;
    // [0] overflow
    logic [0:0]  m_tuser;

    int fail_count;
    int counts_pending;
    int cycle_count = 0;
    bit sender_burst = 0;
    bit sink_burst = 0;

    binomial_and_permutation_count DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bpc_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .counts_pending (counts_pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one pair per call; returns at the falling edge after the transfer
    task automatic send_pair(logic [ARG_W-1:0] n, logic [ARG_W-1:0] k);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, k, n};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // mostly valid pairs with k <= n, some k > n, some beyond the bound
    task automatic send_random_pair();
        logic [ARG_W-1:0] n;
        logic [ARG_W-1:0] k;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            n = ARG_W'($urandom_range(0, int'(MAX_N)));
            k = ARG_W'($urandom_range(0, int'(n)));
        end else if (pick < 87) begin
            n = ARG_W'($urandom_range(0, int'(MAX_N) - 1));
            k = ARG_W'($urandom_range(int'(n) + 1, int'(MAX_N)));
        end else begin
            n = ARG_W'($urandom_range(0, 31));
            k = ARG_W'($urandom_range(0, 31));
        end
        send_pair(n, k);
    endtask

    // result side: with a stall drawn, ready stays low until the result
    // shows and then for that many more cycles
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = sink_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("binomial_and_permutation_count: mismatch");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int i;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corners: k zero, k equal to n, largest products, k above n,
        // arguments beyond the bound
        send_pair(5'd0, 5'd0);
        send_pair(5'd20, 5'd0);
        send_pair(5'd1, 5'd1);
        send_pair(5'd20, 5'd20);
        send_pair(5'd20, 5'd19);
        send_pair(5'd20, 5'd10);
        send_pair(5'd20, 5'd1);
        send_pair(5'd19, 5'd9);
        send_pair(5'd5, 5'd3);
        send_pair(5'd0, 5'd1);
        send_pair(5'd19, 5'd20);
        send_pair(5'd3, 5'd7);
        send_pair(5'd21, 5'd0);
        send_pair(5'd0, 5'd21);
        send_pair(5'd21, 5'd21);
        send_pair(5'd31, 5'd31);
        send_pair(5'd31, 5'd0);
        send_pair(5'd0, 5'd31);
        send_pair(5'd10, 5'd21);
        send_pair(5'd21, 5'd10);

        // random pairs, with stretches free of gaps on either side
        for (i = 0; i < RANDOM_PAIRS; i++) begin
            sender_burst = ((i / 150) % 4) == 1;
            sink_burst   = ((i / 150) % 4) == 2;
            if (i == 600) begin
                s_tvalid <= 1'b0;
                while (counts_pending != 0) @(negedge aclk);
                @(negedge aclk);
            end
            send_random_pair();
        end
        s_tvalid <= 1'b0;

        // drain
        while (counts_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && counts_pending == 0) begin
            $display("binomial_and_permutation_count: match");
        end else begin
            $display("binomial_and_permutation_count: mismatch");
        end
        $finish;
    end

endmodule
